>>> design/pfdc_pkg.sv
// ----------------------------------------------------------------------------
// pfdc_pkg
// Shared types and constants of the PID controller with a filtered derivative
// on the measurement.
// ----------------------------------------------------------------------------
package pfdc_pkg;

  localparam int DataWidthDef = 32;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam int XW       = 32;

  localparam int MulAW = 33;
  localparam int MulBW = 30;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 64;
  localparam int IsW   = 34;

  localparam int FracBits   = 16;
  localparam int SampleRate = 100;
  localparam int RecipShift = 35;
  localparam int QW         = 26;

  localparam logic signed [MulBW-1:0] RecipM  = 30'sd343597383;
  localparam logic signed [MulBW-1:0] RateMul = 30'sd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET   = 4'd0,
    REG_GAIN_P   = 4'd1,
    REG_GAIN_I   = 4'd2,
    REG_GAIN_D   = 4'd3,
    REG_FF_ON    = 4'd4,
    REG_FF_GAIN  = 4'd5,
    REG_INT_LIM  = 4'd6,
    REG_ALPHA    = 4'd7
  } pfdc_reg_e;

  typedef struct packed {
    logic signed [20:0] target_position;
    logic signed [26:0] gain_p;
    logic signed [26:0] gain_i;
    logic signed [26:0] gain_d;
    logic               feedforward_on;
    logic signed [26:0] feedforward_gain;
    logic        [30:0] integ_bound;
    logic        [15:0] derivative_alpha;
  } pfdc_cfg_t;

  localparam pfdc_cfg_t CfgReset = '{
    target_position:  21'sd655360,
    gain_p:           27'sd6488064,
    gain_i:           27'sd327680,
    gain_d:           27'sd1245184,
    feedforward_on:   1'b1,
    feedforward_gain: 27'sd65536,
    integ_bound:      31'd1310720,
    derivative_alpha: 16'd54613
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_RECIP,
    ST_ALPHA,
    ST_BETA,
    ST_QCHK,
    ST_FILT,
    ST_INT,
    ST_CLAMP,
    ST_FF,
    ST_LAST,
    ST_OUT
  } pfdc_state_e;

  typedef enum logic [3:0] {
    MS_DIFF,
    MS_RECIP,
    MS_ALPHA,
    MS_BETA,
    MS_QCHK,
    MS_GP,
    MS_GD,
    MS_FFW,
    MS_GI
  } pfdc_mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_FF
  } pfdc_acc_op_e;

  typedef struct packed {
    logic          ld_in;
    logic          ld_n;
    logic          ld_raw;
    logic          ld_q0;
    logic          ld_fd;
    logic          ld_q;
    logic          ld_isum;
    logic          ld_integ;
    logic          commit;
    pfdc_mul_sel_e mul_sel;
    pfdc_acc_op_e  acc_op;
  } pfdc_ctrl_t;

endpackage

>>> design/pfdc_cfg.sv
// ----------------------------------------------------------------------------
// pfdc_cfg
// Configuration register file, written by index over its own channel.
// ----------------------------------------------------------------------------
module pfdc_cfg import pfdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output pfdc_cfg_t           cfg_o
);

  pfdc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    unique case (pfdc_reg_e'(cfg_index_i))
      REG_TARGET:  cfg_d.target_position  = cfg_data_i[20:0];
      REG_GAIN_P:  cfg_d.gain_p           = cfg_data_i[26:0];
      REG_GAIN_I:  cfg_d.gain_i           = cfg_data_i[26:0];
      REG_GAIN_D:  cfg_d.gain_d           = cfg_data_i[26:0];
      REG_FF_ON:   cfg_d.feedforward_on   = cfg_data_i[0];
      REG_FF_GAIN: cfg_d.feedforward_gain = cfg_data_i[26:0];
      REG_INT_LIM: cfg_d.integ_bound      = cfg_data_i[30:0];
      REG_ALPHA:   cfg_d.derivative_alpha = cfg_data_i[15:0];
      default:     cfg_d = cfg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/pfdc_mul.sv
// ----------------------------------------------------------------------------
// pfdc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pfdc_mul import pfdc_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign p_o = prod_q;

endmodule

>>> design/pfdc_seq.sv
// ----------------------------------------------------------------------------
// pfdc_seq
// Sequencer: steps one item through the shared multiplier and accumulator,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pfdc_seq import pfdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pfdc_ctrl_t ctrl_o
);

  pfdc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o         = '0;
    ctrl_o.mul_sel = MS_DIFF;
    ctrl_o.acc_op  = ACC_HOLD;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.ld_in = in_valid_i;
        if (in_valid_i) state_d = ST_DIFF;
      end
      ST_DIFF: begin
        ctrl_o.mul_sel = MS_DIFF;
        ctrl_o.ld_n    = 1'b1;
        state_d        = ST_RECIP;
      end
      ST_RECIP: begin
        ctrl_o.mul_sel = MS_RECIP;
        ctrl_o.ld_raw  = 1'b1;
        state_d        = ST_ALPHA;
      end
      ST_ALPHA: begin
        ctrl_o.mul_sel = MS_ALPHA;
        ctrl_o.ld_q0   = 1'b1;
        state_d        = ST_BETA;
      end
      ST_BETA: begin
        ctrl_o.mul_sel = MS_BETA;
        ctrl_o.acc_op  = ACC_LOAD;
        state_d        = ST_QCHK;
      end
      ST_QCHK: begin
        ctrl_o.mul_sel = MS_QCHK;
        ctrl_o.acc_op  = ACC_ADD;
        state_d        = ST_FILT;
      end
      ST_FILT: begin
        ctrl_o.mul_sel = MS_GP;
        ctrl_o.ld_fd   = 1'b1;
        ctrl_o.ld_q    = 1'b1;
        state_d        = ST_INT;
      end
      ST_INT: begin
        ctrl_o.mul_sel = MS_GD;
        ctrl_o.acc_op  = ACC_LOAD;
        ctrl_o.ld_isum = 1'b1;
        state_d        = ST_CLAMP;
      end
      ST_CLAMP: begin
        ctrl_o.mul_sel  = MS_FFW;
        ctrl_o.acc_op   = ACC_ADD;
        ctrl_o.ld_integ = 1'b1;
        state_d         = ST_FF;
      end
      ST_FF: begin
        ctrl_o.mul_sel = MS_GI;
        ctrl_o.acc_op  = ACC_ADD_FF;
        state_d        = ST_LAST;
      end
      ST_LAST: begin
        ctrl_o.acc_op = ACC_ADD;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  a_rise_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_DIFF)
    else $error("accepted item did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> state_q == ST_OUT)
    else $error("pending result overwritten");

endmodule

>>> design/pfdc_dpath.sv
// ----------------------------------------------------------------------------
// pfdc_dpath
// Datapath: controller state, operand selection for the shared multiplier,
// accumulator, rounding, saturation and the integral clamp.
// ----------------------------------------------------------------------------
module pfdc_dpath import pfdc_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pfdc_ctrl_t              ctrl_i,
  input  pfdc_cfg_t               cfg_i,
  input  logic signed [XW-1:0]    measured_position_i,
  input  logic signed [ProdW-1:0] prod_i,
  output logic signed [MulAW-1:0] mul_a_o,
  output logic signed [MulBW-1:0] mul_b_o,
  output logic signed [XW-1:0]    drive_force_o,
  output logic signed [XW-1:0]    tracking_error_o
);

  localparam int SatW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int DW   = XW + 1;
  localparam logic signed [AccW-1:0] SatHi   = (AccW'(1) << (SatW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] SatLo   = -SatHi - AccW'(1);
  localparam logic signed [AccW-1:0] RndHalf = AccW'(1) << (FracBits - 1);

  function automatic logic signed [SatW-1:0] sat_w(input logic signed [AccW-1:0] v);
    logic signed [SatW-1:0] r;
    if (v > SatHi) r = SatHi[SatW-1:0];
    else if (v < SatLo) r = SatLo[SatW-1:0];
    else r = v[SatW-1:0];
    return r;
  endfunction

  logic signed [XW-1:0]   x_q;
  logic signed [SatW-1:0] err_q;
  logic signed [SatW-1:0] prev_q;
  logic signed [SatW-1:0] fd_q;
  logic signed [SatW-1:0] integ_q;
  logic signed [SatW-1:0] raw_q;
  logic [MulAW-1:0]       n_q;
  logic                   neg_q;
  logic [QW-1:0]          q0_q;
  logic [QW-1:0]          q_q;
  logic signed [IsW-1:0]  isum_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [XW-1:0]   force_q;
  logic signed [XW-1:0]   terr_q;

  logic signed [DW-1:0]   esub;
  logic signed [DW-1:0]   diff;
  logic [MulAW-1:0]       n_d;
  logic [MulAW-1:0]       rem;
  logic [QW-1:0]          q_d;
  logic signed [IsW-1:0]  q_s;
  logic signed [IsW-1:0]  isum_d;
  logic signed [IsW-1:0]  lim;
  logic signed [IsW-1:0]  clamped;
  logic signed [IsW-1:0]  integ_ext;
  logic signed [AccW-1:0] rnd;
  logic [FracBits:0]      beta;

  assign esub = DW'(cfg_i.target_position) - DW'(measured_position_i);
  assign diff = DW'(prev_q) - DW'(x_q);
  assign n_d  = (err_q[SatW-1] ? -MulAW'(err_q) : MulAW'(err_q)) + MulAW'(SampleRate / 2);
  assign rem  = n_q - prod_i[MulAW-1:0];
  assign q_d  = q0_q + QW'(rem >= MulAW'(SampleRate));
  assign q_s  = $signed({{(IsW - QW){1'b0}}, q_q});
  assign isum_d = IsW'(integ_q) + (neg_q ? -q_s : q_s);
  assign lim  = $signed({{(IsW - 31){1'b0}}, cfg_i.integ_bound});
  assign rnd  = (acc_q + RndHalf) >>> FracBits;
  assign beta = (FracBits + 1)'(1 << FracBits) - (FracBits + 1)'(cfg_i.derivative_alpha);
  assign integ_ext = IsW'(integ_q);

  always_comb begin
    if (isum_q > lim) clamped = lim;
    else if (isum_q < -lim) clamped = -lim;
    else clamped = isum_q;
  end

  always_comb begin
    mul_a_o = MulAW'(diff);
    mul_b_o = RateMul;
    case (ctrl_i.mul_sel)
      MS_DIFF: begin
        mul_a_o = MulAW'(diff);
        mul_b_o = RateMul;
      end
      MS_RECIP: begin
        mul_a_o = n_q;
        mul_b_o = RecipM;
      end
      MS_ALPHA: begin
        mul_a_o = MulAW'(fd_q);
        mul_b_o = MulBW'(cfg_i.derivative_alpha);
      end
      MS_BETA: begin
        mul_a_o = MulAW'(raw_q);
        mul_b_o = MulBW'(beta);
      end
      MS_QCHK: begin
        mul_a_o = MulAW'(q0_q);
        mul_b_o = RateMul;
      end
      MS_GP: begin
        mul_a_o = MulAW'(err_q);
        mul_b_o = MulBW'(cfg_i.gain_p);
      end
      MS_GD: begin
        mul_a_o = MulAW'(fd_q);
        mul_b_o = MulBW'(cfg_i.gain_d);
      end
      MS_FFW: begin
        mul_a_o = MulAW'(cfg_i.target_position);
        mul_b_o = MulBW'(cfg_i.feedforward_gain);
      end
      MS_GI: begin
        mul_a_o = MulAW'(integ_q);
        mul_b_o = MulBW'(cfg_i.gain_i);
      end
      default: begin
        mul_a_o = MulAW'(diff);
        mul_b_o = RateMul;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      fd_q    <= '0;
      integ_q <= '0;
    end else begin
      if (ctrl_i.ld_fd) fd_q <= sat_w(rnd);
      if (ctrl_i.ld_integ) integ_q <= sat_w(AccW'(clamped));
      if (ctrl_i.commit) prev_q <= sat_w(AccW'(x_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in) begin
      x_q   <= measured_position_i;
      err_q <= sat_w(AccW'(esub));
    end
    if (ctrl_i.ld_n) begin
      n_q   <= n_d;
      neg_q <= err_q[SatW-1];
    end
    if (ctrl_i.ld_raw) raw_q <= sat_w(AccW'(prod_i));
    if (ctrl_i.ld_q0) q0_q <= prod_i[RecipShift +: QW];
    if (ctrl_i.ld_q) q_q <= q_d;
    if (ctrl_i.ld_isum) isum_q <= isum_d;
    case (ctrl_i.acc_op)
      ACC_LOAD:   acc_q <= AccW'(prod_i);
      ACC_ADD:    acc_q <= acc_q + AccW'(prod_i);
      ACC_ADD_FF: begin
        if (cfg_i.feedforward_on) acc_q <= acc_q + AccW'(prod_i);
      end
      default:    acc_q <= acc_q;
    endcase
    if (ctrl_i.commit) begin
      force_q <= XW'(sat_w(rnd));
      terr_q  <= XW'(err_q);
    end
  end

  assign drive_force_o    = force_q;
  assign tracking_error_o = terr_q;

  a_quotient_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ld_q |-> rem < MulAW'(2 * SampleRate))
    else $error("reciprocal quotient off by more than one");

  a_integral_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ld_integ |=> (integ_ext <= lim && integ_ext >= -lim))
    else $error("integral outside its limit");

endmodule

>>> design/pid_filtered_derivative_controller_top.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative_controller_top
// PID controller, derivative on measurement through a first-order low-pass,
// clamped integral and optional feed-forward, signed Q16.16.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_ready_o    measured_position_i
//   out      source     out_valid_o / out_ready_i  drive_force_o, tracking_error_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each item sends nine products one after another through the single shared
// multiplier, and no new item is accepted before that sequence has finished;
// its result is registered as the sequencer leaves its output step.
// The input is ready only while the sequencer is idle.
// A result waits in the output register; the next item may run meanwhile and
// stalls in its final step only while that register is still full.
// Reset clears the controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_controller_top import pfdc_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  measured_position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  drive_force_o,
  output logic signed [31:0]  tracking_error_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pfdc_cfg_t               cfg;
  pfdc_ctrl_t              ctrl;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  pfdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfdc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  pfdc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pfdc_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .cfg_i               (cfg),
    .measured_position_i (measured_position_i),
    .prod_i              (prod),
    .mul_a_o             (mul_a),
    .mul_b_o             (mul_b),
    .drive_force_o       (drive_force_o),
    .tracking_error_o    (tracking_error_o)
  );

endmodule

>>> test/tb_pid_filtered_derivative_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_filtered_derivative_controller_top
// Drives measured positions into the PID controller and checks every drive
// force and tracking error against a cycle-free Q16.16 controller model kept
// in step with the register writes. A short directed run covers field
// extremes, error saturation, rounding ties, a zero integral limit and
// unknown register indexes. Random settings phases follow, fed mostly with a
// plant-like walk around the setpoint, mixed with full-range noise.
// ----------------------------------------------------------------------------
module tb_pid_filtered_derivative_controller_top;
  import pfdc_pkg::*;

  localparam longint RateHz = 100;
  localparam int     QFrac  = 16;
  localparam longint SatHi  = 2147483647;
  localparam longint SatLo  = -SatHi - 1;
  localparam int     GainMax   = 65536000;
  localparam int     TargetMax = 655360;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 4'd8;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 4'd15;
  localparam int     NumPhases      = 12;
  localparam int     ItemsPerPhase  = 120;

  typedef struct packed {
    logic signed [31:0] drive_force;
    logic signed [31:0] tracking_error;
  } ctrl_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic signed [31:0]  measured_position_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [31:0]  drive_force_o;
  logic signed [31:0]  tracking_error_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic signed [31:0] position_q[$];
  ctrl_result_t       force_error_q[$];
  logic               in_taken = 1'b0;
  int                 send_idle_pct = 13;
  int                 recv_idle_pct = 46;
  int                 mismatch_count = 0;

  pfdc_cfg_t shadow_cfg;
  longint    prev_pos;
  longint    filt_deriv;
  longint    integ;
  longint    plant_pos;

  pid_filtered_derivative_controller_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .measured_position_i (measured_position_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .drive_force_o       (drive_force_o),
    .tracking_error_o    (tracking_error_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint sat32(input longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  function automatic longint div_rate_rounded(input longint v);
    if (v >= 0) return (v + RateHz / 2) / RateHz;
    return -((-v + RateHz / 2) / RateHz);
  endfunction

  function automatic longint round_q(input longint v);
    return (v + (longint'(1) <<< (QFrac - 1))) >>> QFrac;
  endfunction

  function automatic ctrl_result_t advance_controller(input logic signed [31:0] x);
    longint xs, tgt, err, raw, alpha, lim, acc, drv;
    longint gp, gi, gd, ffg;
    ctrl_result_t r;
    xs    = longint'(x);
    tgt   = longint'(shadow_cfg.target_position);
    gp    = longint'(shadow_cfg.gain_p);
    gi    = longint'(shadow_cfg.gain_i);
    gd    = longint'(shadow_cfg.gain_d);
    ffg   = longint'(shadow_cfg.feedforward_gain);
    lim   = longint'(shadow_cfg.integ_bound);
    alpha = longint'(shadow_cfg.derivative_alpha);
    err = sat32(tgt - xs);
    raw = sat32((prev_pos - xs) * RateHz);
    filt_deriv = sat32(round_q(alpha * filt_deriv
                               + ((longint'(1) <<< QFrac) - alpha) * raw));
    integ = integ + div_rate_rounded(err);
    if (integ > lim) integ = lim;
    if (integ < -lim) integ = -lim;
    integ = sat32(integ);
    acc = gp * err + gi * integ + gd * filt_deriv;
    if (shadow_cfg.feedforward_on) acc = acc + ffg * tgt;
    drv = sat32(round_q(acc));
    prev_pos = sat32(xs);
    r.drive_force    = drv[31:0];
    r.tracking_error = err[31:0];
    return r;
  endfunction

  function automatic void mirror_reg(input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDataW-1:0] data);
    case (idx)
      REG_TARGET:  shadow_cfg.target_position  = data[20:0];
      REG_GAIN_P:  shadow_cfg.gain_p           = data[26:0];
      REG_GAIN_I:  shadow_cfg.gain_i           = data[26:0];
      REG_GAIN_D:  shadow_cfg.gain_d           = data[26:0];
      REG_FF_ON:   shadow_cfg.feedforward_on   = data[0];
      REG_FF_GAIN: shadow_cfg.feedforward_gain = data[26:0];
      REG_INT_LIM: shadow_cfg.integ_bound      = data[30:0];
      REG_ALPHA:   shadow_cfg.derivative_alpha = data[15:0];
      default: ;
    endcase
  endfunction

  // keep the field bits, fill the unused upper bits with noise
  function automatic logic [31:0] cfg_word(input logic [31:0] v, input int w);
    logic [31:0] m;
    m = (w >= 32) ? '1 : ((32'h1 << w) - 32'h1);
    return ($urandom() & ~m) | (v & m);
  endfunction

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return GainMax;
    if (r < 30) return -GainMax;
    if (r < 40) return 0;
    if (r < 70) return int'($urandom_range(0, 1310720)) - 655360;
    return int'($urandom_range(0, 2 * GainMax)) - GainMax;
  endfunction

  function automatic logic [31:0] next_position();
    int r;
    longint tgt;
    r   = $urandom_range(0, 99);
    tgt = longint'(shadow_cfg.target_position);
    if (r < 70) begin
      plant_pos = sat32(plant_pos + (tgt - plant_pos) / 4
                        + longint'($urandom_range(0, 131072)) - 65536);
      return plant_pos[31:0];
    end
    if (r < 85) return $urandom();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return tgt[31:0];
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(input int tgt, input int gp, input int gi, input int gd,
                                input int ffon, input int ffg, input int lim,
                                input int alpha);
    write_reg(REG_TARGET,  cfg_word(tgt, 21));
    write_reg(REG_GAIN_P,  cfg_word(gp, 27));
    write_reg(REG_GAIN_I,  cfg_word(gi, 27));
    write_reg(REG_GAIN_D,  cfg_word(gd, 27));
    write_reg(REG_FF_ON,   cfg_word(ffon, 1));
    write_reg(REG_FF_GAIN, cfg_word(ffg, 27));
    write_reg(REG_INT_LIM, cfg_word(lim, 31));
    write_reg(REG_ALPHA,   cfg_word(alpha, 16));
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (position_q.size() != 0 || in_valid_i || force_error_q.size() != 0);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (int'($urandom_range(0, 99)) >= recv_idle_pct);
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (position_q.size() != 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
        in_valid_i          <= 1'b1;
        measured_position_i <= position_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : observe
    ctrl_result_t want;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      force_error_q.push_back(advance_controller(measured_position_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (force_error_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result force %0d error %0d",
                                  drive_force_o, tracking_error_o));
      end else begin
        want = force_error_q.pop_front();
        if (drive_force_o !== want.drive_force) begin
          report_mismatch($sformatf("drive_force got %0d want %0d",
                                    drive_force_o, want.drive_force));
        end
        if (tracking_error_o !== want.tracking_error) begin
          report_mismatch($sformatf("tracking_error got %0d want %0d",
                                    tracking_error_o, want.tracking_error));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_pid_filtered_derivative_controller_top failed");
    $finish;
  end

  initial begin
    int mode;
    int lim;
    int alpha;
    int tgt;
    shadow_cfg = CfgReset;
    prev_pos   = 0;
    filt_deriv = 0;
    integ      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: extremes, saturated error, rounding ties of the integral step
    position_q.push_back(32'h0000_0000);
    position_q.push_back(32'h7FFF_FFFF);
    position_q.push_back(32'h8000_0000);
    position_q.push_back(32'h7FFF_FFFF);
    position_q.push_back(32'hFFFF_FFFF);
    position_q.push_back(32'h0000_0001);
    position_q.push_back(32'd655360);
    position_q.push_back(32'd655360);
    position_q.push_back(32'd655360);
    position_q.push_back(32'd655410);
    position_q.push_back(32'd655310);
    position_q.push_back(32'd655311);
    wait_drained();

    // zero limit, no low-pass, top gains; unknown indexes must be ignored
    apply_settings(-TargetMax, GainMax, GainMax, GainMax, 1, GainMax, 0, 0);
    write_reg(RegUnusedLo, $urandom());
    write_reg(RegUnusedHi, $urandom());
    position_q.push_back(32'h7FFF_FFFF);
    position_q.push_back(32'h8000_0000);
    position_q.push_back(32'h0000_0000);
    position_q.push_back(32'hA5A5_A5A5);
    position_q.push_back(32'h5A5A_5A5A);
    position_q.push_back(32'hFFF6_0000);
    wait_drained();

    // widest limit, heaviest low-pass, bottom gains, no feed-forward
    apply_settings(TargetMax, -GainMax, -GainMax, -GainMax, 0, -GainMax, 2147483647, 65535);
    position_q.push_back(32'h8000_0000);
    position_q.push_back(32'h7FFF_FFFF);
    position_q.push_back(32'd655360);
    position_q.push_back(32'h0000_0000);
    position_q.push_back(32'hFFFF_0000);
    position_q.push_back(32'h0001_0000);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      mode = ph * 3 / NumPhases;
      send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 46 : 0;
      recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 13 : 0;
      if (ph == 0) begin
        apply_settings(int'(CfgReset.target_position), int'(CfgReset.gain_p),
                       int'(CfgReset.gain_i), int'(CfgReset.gain_d),
                       int'(CfgReset.feedforward_on), int'(CfgReset.feedforward_gain),
                       int'(CfgReset.integ_bound), int'(CfgReset.derivative_alpha));
      end else begin
        case ($urandom_range(0, 9))
          0, 1: tgt = ($urandom_range(0, 1) != 0) ? TargetMax : -TargetMax;
          default: tgt = int'($urandom_range(0, 2 * TargetMax)) - TargetMax;
        endcase
        case ($urandom_range(0, 19))
          0, 1, 2: lim = 0;
          3, 4, 5: lim = 2147483647;
          6, 7, 8, 9, 10, 11, 12: lim = $urandom_range(0, 2621440);
          default: lim = $urandom() & 32'h7FFF_FFFF;
        endcase
        case ($urandom_range(0, 19))
          0, 1, 2: alpha = 0;
          3, 4, 5: alpha = 65535;
          default: alpha = $urandom_range(0, 65535);
        endcase
        apply_settings(tgt, pick_gain(), pick_gain(), pick_gain(), $urandom_range(0, 1),
                       pick_gain(), lim, alpha);
        if ($urandom_range(0, 9) < 3) write_reg(4'(8 + $urandom_range(0, 7)), $urandom());
      end
      plant_pos = longint'(shadow_cfg.target_position);
      for (int n = 0; n < ItemsPerPhase; n++) position_q.push_back(next_position());
      wait_drained();
    end

    repeat (24) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_pid_filtered_derivative_controller_top passed");
    end else begin
      $display("tb_pid_filtered_derivative_controller_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/pfdc_pkg.sv
design/pfdc_cfg.sv
design/pfdc_mul.sv
design/pfdc_seq.sv
design/pfdc_dpath.sv
design/pid_filtered_derivative_controller_top.sv
test/tb_pid_filtered_derivative_controller_top.sv
